// File: src/spti_pkg.sv
// Shared constants, codes and controller/datapath interface types for the term table.
`timescale 1ns / 1ps

package spti_pkg;

    // Default table depth.
    localparam int MAX_TERMS_DEFAULT = 64;

    // Fixed field widths of the item and result channels.
    localparam int KIND_W = 2;
    localparam int COEF_W = 32;
    localparam int EXP_W  = 16;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] REQ_READ   = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_COMBINED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

    // Commands from the controller to the datapath, one step each.
    typedef struct packed {
        logic load_req;    // capture the accepted item
        logic scan_start;  // read entry 0, scan index to 0
        logic scan_step;   // read next entry, advance scan index
        logic combine;     // add coefficient into the matching entry
        logic slot_scan;   // insert slot is the current scan index
        logic slot_count;  // insert slot is the end of the table
        logic shift_start; // read the last entry, shift index to count
        logic shift_step;  // move one entry down, read the one above
        logic place;       // write the new term at the slot
        logic full_drop;   // table full, term dropped
        logic read_issue;  // read the requested entry
        logic read_done;   // report the entry that was read
        logic read_miss;   // report a read beyond the count
        logic clear;       // empty the table
        logic no_req;      // unused request kind
        logic out_load;    // move the prepared result to the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              full;
        logic              eq_hit;
        logic              less_hit;
        logic              scan_last;
        logic              shift_last;
        logic              read_ok;
    } dp_sts_t;

endpackage

// File: src/spti_datapath.sv
// Term memory, scan and shift pointers, term count and result registers.
`timescale 1ns / 1ps

module spti_datapath #(
    parameter int MAX_TERMS = spti_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  spti_pkg::dp_cmd_t                  cmd,
    output spti_pkg::dp_sts_t                  sts,
    input  logic [spti_pkg::KIND_W-1:0]        s_req_type,
    input  logic signed [spti_pkg::COEF_W-1:0] s_term_coef,
    input  logic [spti_pkg::EXP_W-1:0]         s_term_exponent,
    input  logic [spti_pkg::IDX_W-1:0]         s_read_index,
    output logic [spti_pkg::STAT_W-1:0]        m_status,
    output logic [spti_pkg::IDX_W-1:0]         m_position,
    output logic signed [spti_pkg::COEF_W-1:0] m_result_coef,
    output logic [spti_pkg::EXP_W-1:0]         m_result_exponent,
    output logic [spti_pkg::CNT_W-1:0]         m_term_count
);

    localparam int AW   = $clog2(MAX_TERMS);
    localparam int CW   = $clog2(MAX_TERMS + 1);
    localparam int CMPW = CW + spti_pkg::IDX_W;
    localparam int CFW  = spti_pkg::COEF_W;
    localparam int EXW  = spti_pkg::EXP_W;
    localparam int EW   = EXW + CFW;

    // Captured request.
    logic [spti_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic signed [CFW-1:0]       coef_in_reg, coef_in_next;
    logic [EXW-1:0]              exp_in_reg, exp_in_next;
    logic [spti_pkg::IDX_W-1:0]  ridx_reg, ridx_next;

    // Table control.
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic [AW-1:0] shift_idx_reg, shift_idx_next;
    logic [AW-1:0] slot_reg, slot_next;

    // Prepared result and output register.
    logic [spti_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [spti_pkg::IDX_W-1:0]  res_pos_reg, res_pos_next;
    logic signed [CFW-1:0]       res_coef_reg, res_coef_next;
    logic [EXW-1:0]              res_exp_reg, res_exp_next;
    logic [spti_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [spti_pkg::IDX_W-1:0]  m_position_reg, m_position_next;
    logic signed [CFW-1:0]       m_coef_reg, m_coef_next;
    logic [EXW-1:0]              m_exp_reg, m_exp_next;
    logic [spti_pkg::CNT_W-1:0]  m_count_reg, m_count_next;

    // Term memory, one write and one registered read per cycle.
    logic [EW-1:0] term_mem [MAX_TERMS];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_wdata;

    logic signed [CFW-1:0] rd_coef;
    logic [EXW-1:0]        rd_exp;
    logic signed [CFW-1:0] coef_sum;

    assign rd_coef  = rd_data_reg[CFW-1:0];
    assign rd_exp   = rd_data_reg[EW-1:CFW];
    assign coef_sum = rd_coef + coef_in_reg;

    // Status toward the controller.
    always_comb begin
        sts.kind       = kind_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CW'(MAX_TERMS));
        sts.eq_hit     = (rd_exp == exp_in_reg);
        sts.less_hit   = (rd_exp < exp_in_reg);
        sts.scan_last  = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
        sts.shift_last = ((shift_idx_reg - AW'(1)) == slot_reg);
        sts.read_ok    = (CMPW'(ridx_reg) < CMPW'(count_reg));
    end

    // Memory address and data selection.
    always_comb begin
        mem_we    = cmd.combine | cmd.shift_step | cmd.place;
        mem_waddr = slot_reg;
        mem_wdata = {exp_in_reg, coef_in_reg};
        if (cmd.combine) begin
            mem_waddr = scan_idx_reg;
            mem_wdata = {exp_in_reg, coef_sum};
        end else if (cmd.shift_step) begin
            mem_waddr = shift_idx_reg;
            mem_wdata = rd_data_reg;
        end

        priority if (cmd.scan_step) begin
            mem_raddr = scan_idx_reg + AW'(1);
        end else if (cmd.shift_start) begin
            mem_raddr = AW'(count_reg - CW'(1));
        end else if (cmd.shift_step) begin
            mem_raddr = shift_idx_reg - AW'(2);
        end else if (cmd.read_issue) begin
            mem_raddr = AW'(ridx_reg);
        end else begin
            mem_raddr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            term_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= term_mem[mem_raddr];
    end

    // Next-state logic for request, pointers, count and results.
    always_comb begin
        kind_next       = kind_reg;
        coef_in_next    = coef_in_reg;
        exp_in_next     = exp_in_reg;
        ridx_next       = ridx_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        shift_idx_next  = shift_idx_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_coef_next   = res_coef_reg;
        res_exp_next    = res_exp_reg;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        m_coef_next     = m_coef_reg;
        m_exp_next      = m_exp_reg;
        m_count_next    = m_count_reg;

        if (cmd.load_req) begin
            kind_next    = s_req_type;
            coef_in_next = s_term_coef;
            exp_in_next  = s_term_exponent;
            ridx_next    = s_read_index;
        end

        if (cmd.scan_start) begin
            scan_idx_next = '0;
        end else if (cmd.scan_step) begin
            scan_idx_next = scan_idx_reg + AW'(1);
        end

        if (cmd.shift_start) begin
            shift_idx_next = AW'(count_reg);
        end else if (cmd.shift_step) begin
            shift_idx_next = shift_idx_reg - AW'(1);
        end

        if (cmd.slot_scan) begin
            slot_next = scan_idx_reg;
        end else if (cmd.slot_count) begin
            slot_next = AW'(count_reg);
        end

        if (cmd.place) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.clear) begin
            count_next = '0;
        end

        // Prepare the result of the finishing step.
        if (cmd.combine) begin
            res_status_next = spti_pkg::STAT_COMBINED;
            res_pos_next    = spti_pkg::IDX_W'(scan_idx_reg);
            res_coef_next   = coef_sum;
            res_exp_next    = exp_in_reg;
        end else if (cmd.place) begin
            res_status_next = spti_pkg::STAT_OK;
            res_pos_next    = spti_pkg::IDX_W'(slot_reg);
            res_coef_next   = coef_in_reg;
            res_exp_next    = exp_in_reg;
        end else if (cmd.read_done) begin
            res_status_next = spti_pkg::STAT_OK;
            res_pos_next    = ridx_reg;
            res_coef_next   = rd_coef;
            res_exp_next    = rd_exp;
        end else if (cmd.read_miss) begin
            res_status_next = spti_pkg::STAT_RANGE;
            res_pos_next    = ridx_reg;
            res_coef_next   = '0;
            res_exp_next    = '0;
        end else if (cmd.full_drop) begin
            res_status_next = spti_pkg::STAT_FULL;
            res_pos_next    = '0;
            res_coef_next   = '0;
            res_exp_next    = '0;
        end else if (cmd.clear | cmd.no_req) begin
            res_status_next = spti_pkg::STAT_OK;
            res_pos_next    = '0;
            res_coef_next   = '0;
            res_exp_next    = '0;
        end

        // Hand the prepared result to the output register.
        if (cmd.out_load) begin
            m_status_next   = res_status_reg;
            m_position_next = res_pos_reg;
            m_coef_next     = res_coef_reg;
            m_exp_next      = res_exp_reg;
            m_count_next    = spti_pkg::CNT_W'(count_reg);
        end
    end

    // The term count is the only register here with a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        coef_in_reg    <= coef_in_next;
        exp_in_reg     <= exp_in_next;
        ridx_reg       <= ridx_next;
        scan_idx_reg   <= scan_idx_next;
        shift_idx_reg  <= shift_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_coef_reg   <= res_coef_next;
        res_exp_reg    <= res_exp_next;
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
        m_coef_reg     <= m_coef_next;
        m_exp_reg      <= m_exp_next;
        m_count_reg    <= m_count_next;
    end

    assign m_status          = m_status_reg;
    assign m_position        = m_position_reg;
    assign m_result_coef     = m_coef_reg;
    assign m_result_exponent = m_exp_reg;
    assign m_term_count      = m_count_reg;

    // The count never exceeds the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_TERMS))
        else $error("term count beyond table depth");

    // A new term is never written into a full table.
    a_no_place_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.place |-> !sts.full)
        else $error("term placed into a full table");

    // Entries are only moved into places below the insert slot.
    a_shift_above_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step |-> (shift_idx_reg > slot_reg))
        else $error("entry moved into or above the insert slot");

endmodule

// File: src/spti_controller.sv
// Request sequencer: decodes each item and steps the datapath through scan, shift and reply.
`timescale 1ns / 1ps

module spti_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output spti_pkg::dp_cmd_t cmd,
    input  spti_pkg::dp_sts_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // State transitions and command generation.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.kind)
                    spti_pkg::REQ_INSERT: begin
                        if (sts.count_zero) begin
                            cmd.slot_count = 1'b1;
                            state_next     = S_PLACE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    spti_pkg::REQ_READ: begin
                        if (sts.read_ok) begin
                            cmd.read_issue = 1'b1;
                            state_next     = S_READ;
                        end else begin
                            cmd.read_miss = 1'b1;
                            state_next    = S_DONE;
                        end
                    end
                    spti_pkg::REQ_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default: begin
                        cmd.no_req = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // One entry compared per cycle, the next one already being read.
                priority if (sts.eq_hit) begin
                    cmd.combine = 1'b1;
                    state_next  = S_DONE;
                end else if (sts.less_hit || sts.scan_last) begin
                    if (sts.full) begin
                        cmd.full_drop = 1'b1;
                        state_next    = S_DONE;
                    end else if (sts.less_hit) begin
                        cmd.slot_scan   = 1'b1;
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end else begin
                        cmd.slot_count = 1'b1;
                        state_next     = S_PLACE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (sts.shift_last) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_READ: begin
                cmd.read_done = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a load, cleared when the item is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("result register overwritten before it was taken");

    // An accepted item always goes to decode next.
    a_load_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_req |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    // Loading a result presents it and frees the block.
    a_load_present: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("loaded result not presented");

endmodule

// File: src/sorted_poly_term_insert_unit.sv
// Top level of the sorted polynomial term table.
`timescale 1ns / 1ps

// Holds up to MAX_TERMS polynomial terms sorted by descending exponent in a
// single-port-write, registered-read memory. One item is handled at a time and
// each gives exactly one result. An insert scans the table one entry per cycle
// until it meets an equal or lower exponent or the end of the table; an equal
// exponent has the coefficient added in place, a full table drops the term, and
// otherwise the lower entries are moved down one per cycle and the new term is
// written. Scan and shift speed is set by the one memory read and one memory
// write per cycle. Reads within the count go to the memory; reads beyond it,
// clears and unused request kinds do not. A new item is accepted while the
// previous result still waits on the output register.
// Table contents are not cleared by reset; only the term count is.
module sorted_poly_term_insert_unit #(
    parameter int MAX_TERMS = spti_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spti_pkg::KIND_W-1:0]        s_req_type,
    input  logic signed [spti_pkg::COEF_W-1:0] s_term_coef,
    input  logic [spti_pkg::EXP_W-1:0]         s_term_exponent,
    input  logic [spti_pkg::IDX_W-1:0]         s_read_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [spti_pkg::STAT_W-1:0]        m_status,
    output logic [spti_pkg::IDX_W-1:0]         m_position,
    output logic signed [spti_pkg::COEF_W-1:0] m_result_coef,
    output logic [spti_pkg::EXP_W-1:0]         m_result_exponent,
    output logic [spti_pkg::CNT_W-1:0]         m_term_count
);

    spti_pkg::dp_cmd_t cmd;
    spti_pkg::dp_sts_t sts;

    // Sequencer.
    spti_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Table memory and result path.
    spti_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_req_type        (s_req_type),
        .s_term_coef       (s_term_coef),
        .s_term_exponent   (s_term_exponent),
        .s_read_index      (s_read_index),
        .m_status          (m_status),
        .m_position        (m_position),
        .m_result_coef     (m_result_coef),
        .m_result_exponent (m_result_exponent),
        .m_term_count      (m_term_count)
    );

endmodule
